// ----- rtl/cepwm_pkg.sv -----
// Shared types, register codes and constants for the contactor economizer PWM block.
// Holds the economizer duty table builder used by the register file.
// No dependencies.
package cepwm_pkg;

    // Default PWM period; the top level hands it down as a parameter.
    localparam int unsigned PWM_PERIOD_DEF = 4096;

    // Saturation point of the on-tick counters and ceiling of the percent setting.
    localparam int          TICK_LIMIT  = 127;
    localparam int unsigned PERCENT_MAX = 100;

    // Field widths.
    localparam int CFG_W   = 7;
    localparam int DUTY_W  = 16;
    localparam int TICKS_W = 8;
    localparam int REQ_W   = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Register reset values.
    localparam logic [CFG_W-1:0] ECON_PCT_RST   = 7'd50;
    localparam logic [CFG_W-1:0] FULL_TICKS_RST = 7'd6;
    localparam logic [CFG_W-1:0] STAGGER_RST    = 7'd11;

    // Register indexes (word address = paddr[3:2]).
    localparam logic [1:0] REG_ECON_PCT   = 2'd0;
    localparam logic [1:0] REG_FULL_TICKS = 2'd1;
    localparam logic [1:0] REG_STAGGER    = 2'd2;

    typedef logic [DUTY_W-1:0]         t_duty;
    typedef logic signed [TICKS_W-1:0] t_ticks;
    typedef logic [PERCENT_MAX:0][DUTY_W-1:0] t_duty_table;

    // Configuration as seen by the channels.
    typedef struct packed {
        logic [CFG_W-1:0] econ_pct;
        logic [CFG_W-1:0] full_ticks;
        logic [CFG_W-1:0] stagger;
        t_duty            econ_duty;
    } t_cfg;

    // Reduced duty for every percent setting, worked out at elaboration.
    function automatic t_duty_table econ_table(input int unsigned period);
        t_duty_table tbl;
        int unsigned prod;
        tbl = '0;
        for (int unsigned i = 0; i <= PERCENT_MAX; i++) begin
            prod              = (i * period) / PERCENT_MAX;
            tbl[i[CFG_W-1:0]] = prod[DUTY_W-1:0];
        end
        return tbl;
    endfunction

endpackage

// ----- rtl/cepwm_regs.sv -----
// Configuration register file with an APB-style slave port.
// Depends on cepwm_pkg; supplies the economizer duty from a constant table.
module cepwm_regs #(
    parameter int unsigned PWM_PERIOD = cepwm_pkg::PWM_PERIOD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cepwm_pkg::ADDR_W-1:0]  paddr,
    input  logic [cepwm_pkg::DATA_W-1:0]  pwdata,
    output logic [cepwm_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output cepwm_pkg::t_cfg               o_cfg
);
    import cepwm_pkg::*;

    localparam t_duty_table EconTable = econ_table(PWM_PERIOD);

    logic [CFG_W-1:0] r_econ_pct;
    logic [CFG_W-1:0] r_full_ticks;
    logic [CFG_W-1:0] r_stagger;
    logic [CFG_W-1:0] n_econ_pct;
    logic [CFG_W-1:0] wr_value;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[ADDR_W-1:2];
    assign wr_en    = psel && penable && pwrite && pready;
    assign wr_value = pwdata[CFG_W-1:0];

    // The percent setting is clamped to PERCENT_MAX (the full period) on write.
    assign n_econ_pct = (wr_value > CFG_W'(PERCENT_MAX)) ? CFG_W'(PERCENT_MAX) : wr_value;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_econ_pct   <= ECON_PCT_RST;
            r_full_ticks <= FULL_TICKS_RST;
            r_stagger    <= STAGGER_RST;
        end else if (wr_en) begin
            if (reg_idx == REG_ECON_PCT) begin
                r_econ_pct <= n_econ_pct;
            end
            if (reg_idx == REG_FULL_TICKS) begin
                r_full_ticks <= wr_value;
            end
            if (reg_idx == REG_STAGGER) begin
                r_stagger <= wr_value;
            end
        end
    end

    // Read back.
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_ECON_PCT) begin
            prdata = DATA_W'(r_econ_pct);
        end else if (reg_idx == REG_FULL_TICKS) begin
            prdata = DATA_W'(r_full_ticks);
        end else if (reg_idx == REG_STAGGER) begin
            prdata = DATA_W'(r_stagger);
        end
    end

    // The stored percent never exceeds the table range.
    assign o_cfg.econ_pct   = r_econ_pct;
    assign o_cfg.full_ticks = r_full_ticks;
    assign o_cfg.stagger    = r_stagger;
    assign o_cfg.econ_duty  = EconTable[r_econ_pct];

endmodule

// ----- rtl/cepwm_channel.sv -----
// One contactor channel: on-tick counter and held duty, updated once per beat.
// Depends on cepwm_pkg.
module cepwm_channel #(
    parameter int unsigned PWM_PERIOD = cepwm_pkg::PWM_PERIOD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_request,
    input  cepwm_pkg::t_ticks             i_clear_ticks,
    input  logic [cepwm_pkg::CFG_W-1:0]   i_full_ticks,
    input  cepwm_pkg::t_duty              i_econ_duty,
    output cepwm_pkg::t_duty              o_duty
);
    import cepwm_pkg::*;

    localparam t_duty FullDuty = DUTY_W'(PWM_PERIOD);

    t_ticks r_ticks;
    t_ticks n_ticks;
    t_duty  r_duty;
    t_duty  n_duty;

    // Full duty on the first tick, reduced duty once the full-power time is over;
    // the reduced duty wins when both apply.
    always_comb begin
        n_duty  = r_duty;
        n_ticks = r_ticks;
        if (i_request) begin
            if (r_ticks == '0) begin
                n_duty = FullDuty;
            end
            if (r_ticks >= $signed({1'b0, i_full_ticks})) begin
                n_duty = i_econ_duty;
            end
            if (r_ticks < TICKS_W'(TICK_LIMIT)) begin
                n_ticks = r_ticks + t_ticks'(1);
            end
        end else begin
            n_duty  = '0;
            n_ticks = i_clear_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
            r_duty  <= '0;
        end else if (i_step) begin
            r_ticks <= n_ticks;
            r_duty  <= n_duty;
        end
    end

    assign o_duty = r_duty;

endmodule

// ----- rtl/contactor_economizer_pwm_top.sv -----
// Top level of the contactor economizer PWM block.
// Depends on cepwm_pkg, cepwm_regs and cepwm_channel.
//
// One request beat is taken per clock cycle while o_in_ready is high, and its
// result beat appears in the next cycle; the two channels' held duty registers are
// the result register, so the next request is accepted while a result waits as long
// as that result is taken in the same cycle. Each beat takes one pass of counter
// compare and increment logic per channel. The reduced duty comes from a constant
// table of 101 entries built from PWM_PERIOD, so a new percent setting is in force
// on the next beat. After reset both counters are zero; there is no clearing pass.
module contactor_economizer_pwm_top #(
    parameter int unsigned PWM_PERIOD = cepwm_pkg::PWM_PERIOD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cepwm_pkg::ADDR_W-1:0]  paddr,
    input  logic [cepwm_pkg::DATA_W-1:0]  pwdata,
    output logic [cepwm_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cepwm_pkg::REQ_W-1:0]   i_contactor_request,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cepwm_pkg::DUTY_W-1:0]  o_duty_one,
    output logic [cepwm_pkg::DUTY_W-1:0]  o_duty_two,
    output logic                          o_driver_enable
);
    import cepwm_pkg::*;

    t_cfg   cfg;
    t_ticks clear_two;
    logic   in_beat;
    logic   r_out_valid;

    cepwm_regs #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Result slot is free when empty or being drained this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    // Channel two restarts behind channel one by the stagger time.
    assign clear_two = -$signed({1'b0, cfg.stagger});

    cepwm_channel #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_chan_one (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_beat),
        .i_request     (i_contactor_request[0]),
        .i_clear_ticks ('0),
        .i_full_ticks  (cfg.full_ticks),
        .i_econ_duty   (cfg.econ_duty),
        .o_duty        (o_duty_one)
    );

    cepwm_channel #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_chan_two (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_beat),
        .i_request     (i_contactor_request[1]),
        .i_clear_ticks (clear_two),
        .i_full_ticks  (cfg.full_ticks),
        .i_econ_duty   (cfg.econ_duty),
        .o_duty        (o_duty_two)
    );

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_driver_enable = (o_duty_one != '0) || (o_duty_two != '0);

    // A dropped request shows zero duty in the very next result.
    a_drop_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !i_contactor_request[0]) |=> (o_duty_one == '0))
        else $error("duty_one not cleared after request dropped");

    a_drop_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !i_contactor_request[1]) |=> (o_duty_two == '0))
        else $error("duty_two not cleared after request dropped");

    // Every accepted beat yields a result beat in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_out_valid)
        else $error("accepted beat produced no result");

    // A result waiting on the output is not overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_duty_one) && $stable(o_duty_two)))
        else $error("pending result changed while stalled");

endmodule

// ----- dv/contactor_economizer_pwm_top_test.sv -----
// Self-checking testbench for contactor_economizer_pwm_top: a directed table, then
// random request runs under random flow control, every result beat checked in order.
// Depends on cepwm_pkg and the RTL of the block; needs no files or arguments.
module contactor_economizer_pwm_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cepwm_pkg::*;

    localparam int unsigned PERIOD = PWM_PERIOD_DEF;
    localparam int RANDOM_PHASES    = 12;
    localparam int PHASE_ITEMS      = 135;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS      = 10;

    // Index that decodes to no register.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [REQ_W-1:0] REQ_NONE = 2'b00;
    localparam logic [REQ_W-1:0] REQ_ONE  = 2'b01;
    localparam logic [REQ_W-1:0] REQ_TWO  = 2'b10;
    localparam logic [REQ_W-1:0] REQ_BOTH = 2'b11;

    typedef struct packed {
        t_duty duty_one;
        t_duty duty_two;
        logic  driver_enable;
    } t_duty_beat;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [1:0]       reg_idx;
        logic [CFG_W-1:0] value;
        logic [REQ_W-1:0] req;
        logic             fixed;
        t_duty_beat       want;
    } t_plan_row;

    typedef enum int { DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_MOSTLY } t_drain_mode;

    localparam t_duty_beat NO_BEAT   = '0;
    localparam t_duty_beat ALL_OFF   = '0;
    localparam t_duty_beat FULL_BOTH = '{t_duty'(PERIOD), t_duty'(PERIOD), 1'b1};

    // Directed table: reset behavior, full then reduced duty, stagger, clamped percent,
    // zero full-power ticks, zero reduced duty, unknown register, largest settings.
    localparam t_plan_row PLAN [0:35] = '{
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b1, FULL_BOTH},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_NONE, 1'b1, ALL_OFF},
        '{ROW_REQ, '0, '0, REQ_TWO,  1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_ONE,  1'b0, NO_BEAT},
        '{ROW_CFG, REG_ECON_PCT,   7'd127, REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_FULL_TICKS, 7'd0,   REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_STAGGER,    7'd0,   REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_NONE, 1'b1, ALL_OFF},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_ECON_PCT,   7'd0,   REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_NONE, 1'b1, ALL_OFF},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b1, ALL_OFF},
        '{ROW_CFG, REG_UNUSED,     7'd55,  REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_ECON_PCT,   7'd100, REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_FULL_TICKS, 7'd127, REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_STAGGER,    7'd127, REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_NONE, 1'b1, ALL_OFF},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_ONE,  1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_TWO,  1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_ECON_PCT,   7'd33,  REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_FULL_TICKS, 7'd2,   REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_STAGGER,    7'd3,   REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_NONE, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT},
        '{ROW_REQ, '0, '0, REQ_BOTH, 1'b0, NO_BEAT}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [REQ_W-1:0]     i_contactor_request;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [DUTY_W-1:0]    o_duty_one;
    logic [DUTY_W-1:0]    o_duty_two;
    logic                 o_driver_enable;

    // Predictor copy of the settings and of the channel state.
    logic [CFG_W-1:0] set_econ_pct;
    logic [CFG_W-1:0] set_full_ticks;
    logic [CFG_W-1:0] set_stagger;
    t_ticks           ticks_one;
    t_ticks           ticks_two;
    t_duty            hold_one;
    t_duty            hold_two;

    t_duty_beat due_beats [$];

    int failures      = 0;
    int reports       = 0;
    int beats_checked = 0;
    int items_sent    = 0;
    int writes_done   = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    int burst_left    = 0;
    bit sender_steady = 1'b0;

    contactor_economizer_pwm_top u_top (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2000000;
        $display("contactor_economizer_pwm_top_test: errors");
        $finish;
    end

    // Holding duty for the current percent setting, rounded down.
    function automatic t_duty reduced_duty();
        int unsigned prod;
        prod = (set_econ_pct * PERIOD) / PERCENT_MAX;
        return prod[DUTY_W-1:0];
    endfunction

    // One tick of a requested channel: pick the duty, then count up to the limit.
    function automatic void advance_channel(inout t_ticks ticks, inout t_duty duty);
        if (ticks == 0)
            duty = t_duty'(PERIOD);
        if (int'(ticks) >= int'(set_full_ticks))
            duty = reduced_duty();
        if (int'(ticks) < TICK_LIMIT)
            ticks = ticks + 8'sd1;
    endfunction

    // Applies one request to both channels and returns the duties it leaves.
    function automatic t_duty_beat tick_contactors(input logic [REQ_W-1:0] req);
        t_duty_beat beat;
        if (req[0]) begin
            advance_channel(ticks_one, hold_one);
        end else begin
            hold_one  = '0;
            ticks_one = '0;
        end
        if (req[1]) begin
            advance_channel(ticks_two, hold_two);
        end else begin
            hold_two  = '0;
            ticks_two = t_ticks'(-int'(set_stagger));
        end
        beat.duty_one      = hold_one;
        beat.duty_two      = hold_two;
        beat.driver_enable = (hold_one != 0) || (hold_two != 0);
        return beat;
    endfunction

    // Offers one request beat, with burst gaps, and records what it should produce.
    task automatic offer_request(input logic [REQ_W-1:0] req, input logic fixed,
                                 input t_duty_beat want);
        int         gap;
        t_duty_beat beat;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid          <= 1'b1;
        i_contactor_request <= req;
        do @(posedge i_clk); while (!o_in_ready);
        beat = tick_contactors(req);
        due_beats.push_back(fixed ? want : beat);
        items_sent++;
        @(negedge i_clk);
    endtask

    // APB write with random upper data bits; the predictor takes it once accepted.
    task automatic write_setting(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        logic [DATA_W-1:0] data;
        data = $urandom();
        data[CFG_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_ECON_PCT:   set_econ_pct   = (val > PERCENT_MAX) ? 7'(PERCENT_MAX) : val;
            REG_FULL_TICKS: set_full_ticks = val;
            REG_STAGGER:    set_stagger    = val;
            default: ;
        endcase
        writes_done++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every expected beat has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Result checker: each accepted beat against the oldest expectation.
    always @(posedge i_clk) begin : check_beats
        t_duty_beat seen;
        t_duty_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_duty_one, o_duty_two, o_driver_enable};
            if (due_beats.size() == 0) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("result beat with nothing outstanding: %0d/%0d/%0d",
                             seen.duty_one, seen.duty_two, seen.driver_enable);
                end
            end else begin
                want = due_beats.pop_front();
                beats_checked++;
                if (seen.duty_one !== want.duty_one || seen.duty_two !== want.duty_two ||
                    seen.driver_enable !== want.driver_enable) begin
                    failures++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("duty beat %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 beats_checked, want.duty_one, want.duty_two,
                                 want.driver_enable, seen.duty_one, seen.duty_two,
                                 seen.driver_enable);
                    end
                end
            end
        end
    end

    // Output side: stall patterns that change now and then, plus long hold-offs on request.
    initial begin : out_flow
        t_drain_mode mode;
        int          mode_left;
        int          hold_left;
        int          phase;
        i_out_ready = 1'b0;
        mode        = DRAIN_FREE;
        mode_left   = 0;
        hold_left   = 0;
        phase       = 0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_drain_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    DRAIN_FREE:   i_out_ready <= 1'b1;
                    DRAIN_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    DRAIN_SPARSE: i_out_ready <= (phase % 4 == 0);
                    default:      i_out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Stimulus: reset, directed table, then random phases with fresh settings.
    initial begin : stimulus
        int               remaining;
        int               run_len;
        logic [REQ_W-1:0] req;
        logic [CFG_W-1:0] val;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        i_in_valid          = 1'b0;
        i_contactor_request = '0;
        set_econ_pct        = ECON_PCT_RST;
        set_full_ticks      = FULL_TICKS_RST;
        set_stagger         = STAGGER_RST;
        ticks_one           = '0;
        ticks_two           = '0;
        hold_one            = '0;
        hold_two            = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < $size(PLAN); r++) begin
            if (PLAN[r].kind == ROW_CFG) begin
                settle();
                write_setting(PLAN[r].reg_idx, PLAN[r].value);
            end else begin
                offer_request(PLAN[r].req, PLAN[r].fixed, PLAN[r].want);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            // New settings, extremes included; an over-range percent gets clamped.
            for (int idx = 0; idx < 3; idx++) begin
                if (p == 0 || $urandom_range(0, 2) != 0) begin
                    case ($urandom_range(0, 5))
                        0:       val = '0;
                        1:       val = (idx == REG_ECON_PCT) ? 7'($urandom_range(101, 127))
                                                             : 7'd127;
                        2:       val = 7'($urandom());
                        default: val = (idx == REG_ECON_PCT) ? 7'($urandom_range(0, 100))
                                                             : 7'($urandom_range(0, 20));
                    endcase
                    write_setting(2'(idx), val);
                end
            end
            if ($urandom_range(0, 3) == 0)
                write_setting(REG_UNUSED, 7'($urandom()));

            sender_steady = ($urandom_range(0, 3) == 0);
            if (p == 2 || p == 7 || $urandom_range(0, 5) == 0)
                holds_asked++;

            // Mostly held requests as in real use, some long enough to saturate.
            remaining = PHASE_ITEMS;
            while (remaining > 0) begin
                if ($urandom_range(0, 4) == 0) begin
                    offer_request(2'($urandom()), 1'b0, NO_BEAT);
                    remaining--;
                end else begin
                    req     = 2'($urandom());
                    run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(130, 180)
                                                          : $urandom_range(1, 30);
                    if (run_len > remaining)
                        run_len = remaining;
                    repeat (run_len) offer_request(req, 1'b0, NO_BEAT);
                    remaining -= run_len;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d request beats, checked %0d duty beats, %0d register writes.",
                 items_sent, beats_checked, writes_done);
        $display("Random part: %0d setting phases, %0d long output hold-offs, %0d failures.",
                 RANDOM_PHASES, holds_done, failures);
        if (failures == 0)
            $display("contactor_economizer_pwm_top_test: clean");
        else
            $display("contactor_economizer_pwm_top_test: errors");
        $finish;
    end

endmodule
